[rtl/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared types and fixed field widths for the lru page replacement core
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int REQ_DATA_W  = 8;
   localparam int FRAME_IDX_W = 4;
   localparam int EV_PAGE_W   = 8;
   localparam int FAULT_W     = 16;
   localparam int RSP_FIELD_W = FRAME_IDX_W + 1 + EV_PAGE_W + FAULT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

   typedef struct packed {
      logic capture;
      logic look;
      logic scan;
      logic write;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic page_zero;
      logic hit;
      logic has_empty;
      logic scan_last;
   } status_type;

endpackage

[rtl/lrupr_ctrl.sv]
// ----------------------------------------------------------------------------
// lrupr_ctrl
// sequencer for lookup, victim scan, replacement and result handoff
// ----------------------------------------------------------------------------
module lrupr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  lrupr_pkg::status_type  status,
   output lrupr_pkg::cmd_type     cmd
);
   import lrupr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff && !rsp_tready;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            if (status.page_zero || status.hit || status.has_empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[rtl/lrupr_datapath.sv]
// ----------------------------------------------------------------------------
// lrupr_datapath
// frame table, aging counters, victim scan and result registers
// ----------------------------------------------------------------------------
module lrupr_datapath #(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 8,
   parameter int AGE_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lrupr_pkg::cmd_type                  cmd,
   output lrupr_pkg::status_type               status,
   input  logic [lrupr_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic [lrupr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser
);
   import lrupr_pkg::*;

   localparam int SLOT_BITS = $clog2(FRAMES);
   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   logic [PAGE_BITS-1:0] pages_ff [FRAMES];
   logic [PAGE_BITS-1:0] pages_in [FRAMES];
   logic [AGE_BITS-1:0]  ages_ff  [FRAMES];
   logic [AGE_BITS-1:0]  ages_in  [FRAMES];
   logic [FAULT_W-1:0]   faults_ff, faults_in;

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [SLOT_BITS-1:0] cnt_ff, cnt_in;
   logic [AGE_BITS-1:0]  best_ff, best_in;
   logic                 hit_ff, hit_in;
   logic                 ev_ff, ev_in;
   logic [PAGE_BITS-1:0] ev_page_ff, ev_page_in;

   logic                   out_hit_ff;
   logic [FRAME_IDX_W-1:0] out_idx_ff;
   logic                   out_ev_ff;
   logic [EV_PAGE_W-1:0]   out_ev_page_ff;
   logic [FAULT_W-1:0]     out_fault_ff;

   logic [FRAMES-1:0]    match;
   logic [FRAMES-1:0]    empty;
   logic                 any_hit, any_empty, page_zero;
   logic [SLOT_BITS-1:0] hit_idx, empty_idx;
   logic                 hit_found, empty_found;

   // parallel compare and lowest-index select
   always_comb begin
      hit_idx     = '0;
      empty_idx   = '0;
      hit_found   = 1'b0;
      empty_found = 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
         match[i] = (pages_ff[i] == page_ff);
         empty[i] = (pages_ff[i] == '0);
         if (match[i] && !hit_found) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_BITS'(i);
         end
         if (empty[i] && !empty_found) begin
            empty_found = 1'b1;
            empty_idx   = SLOT_BITS'(i);
         end
      end
   end

   assign page_zero = (page_ff == '0);
   assign any_hit   = hit_found && !page_zero;
   assign any_empty = empty_found;

   assign status.page_zero = page_zero;
   assign status.hit       = any_hit;
   assign status.has_empty = any_empty;
   assign status.scan_last = (cnt_ff == SLOT_BITS'(FRAMES - 1));

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         pages_in[i] = pages_ff[i];
         ages_in[i]  = ages_ff[i];
      end
      faults_in  = faults_ff;
      page_in    = page_ff;
      slot_in    = slot_ff;
      cnt_in     = cnt_ff;
      best_in    = best_ff;
      hit_in     = hit_ff;
      ev_in      = ev_ff;
      ev_page_in = ev_page_ff;

      if (cmd.capture) begin
         page_in = PAGE_BITS'(req_tdata);
      end

      if (cmd.look) begin
         hit_in     = any_hit;
         ev_in      = 1'b0;
         ev_page_in = '0;
         cnt_in     = '0;
         best_in    = '0;
         slot_in    = '0;
         if (!page_zero) begin
            // occupied frames age, saturating
            for (int i = 0; i < FRAMES; i++) begin
               if (!empty[i] && ages_ff[i] != AGE_MAX) begin
                  ages_in[i] = ages_ff[i] + AGE_BITS'(1);
               end
            end
            if (any_hit) begin
               slot_in          = hit_idx;
               ages_in[hit_idx] = '0;
            end else begin
               if (faults_ff != FAULT_MAX) begin
                  faults_in = faults_ff + FAULT_W'(1);
               end
               if (any_empty) begin
                  slot_in            = empty_idx;
                  pages_in[empty_idx] = page_ff;
                  ages_in[empty_idx]  = '0;
               end
            end
         end
      end

      // one frame per cycle, ties go to the higher index
      if (cmd.scan) begin
         if (ages_ff[cnt_ff] >= best_ff) begin
            best_in = ages_ff[cnt_ff];
            slot_in = cnt_ff;
         end
         cnt_in = cnt_ff + SLOT_BITS'(1);
      end

      if (cmd.write) begin
         ev_in             = 1'b1;
         ev_page_in        = pages_ff[slot_ff];
         pages_in[slot_ff] = page_ff;
         ages_in[slot_ff]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            pages_ff[i] <= '0;
            ages_ff[i]  <= '0;
         end
         faults_ff <= '0;
      end else begin
         for (int i = 0; i < FRAMES; i++) begin
            pages_ff[i] <= pages_in[i];
            ages_ff[i]  <= ages_in[i];
         end
         faults_ff <= faults_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      slot_ff    <= slot_in;
      cnt_ff     <= cnt_in;
      best_ff    <= best_in;
      hit_ff     <= hit_in;
      ev_ff      <= ev_in;
      ev_page_ff <= ev_page_in;
      if (cmd.load) begin
         out_hit_ff     <= hit_ff;
         out_idx_ff     <= FRAME_IDX_W'(slot_ff);
         out_ev_ff      <= ev_ff;
         out_ev_page_ff <= EV_PAGE_W'(ev_page_ff);
         out_fault_ff   <= faults_ff;
      end
   end

   assign rsp_tuser = out_hit_ff;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_fault_ff, out_ev_page_ff, out_ev_ff,
                       out_idx_ff};

endmodule

[rtl/lru_page_replacement_core.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// lru page replacement with per-frame aging counters
// ----------------------------------------------------------------------------
// each request carries one page reference; each produces exactly one response
// that reports hit or fault, the frame that now holds the page, the evicted
// page if any and the saturating fault count.
// req_tready is high only while the sequencer is idle. a page zero request,
// a hit, or a fault that finds an empty frame goes from the look state to
// the done state, which loads the response register; a fault with all
// frames full adds a victim scan state (one frame per cycle over the age
// counters) and a replacement write state between the two. the next request
// is taken in the cycle after the response is loaded, so no new request is
// accepted while one is still in flight.
// the response register holds while rsp_tready is low; a finished request
// waits in the sequencer until the register is free, and new requests are
// accepted while an earlier response is still waiting.
// reset empties all frames, clears ages and the fault count, drops
// rsp_tvalid and leaves the block ready for a request.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 8,
   parameter int AGE_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] page_number
   input  logic [lrupr_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [3:0] frame_index, [4] evicted, [12:5] evicted_page, [28:13] fault_count
   output logic [lrupr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] hit
   output logic                                rsp_tuser
);
   import lrupr_pkg::*;

   cmd_type    cmd;
   status_type status;

   lrupr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lrupr_datapath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .AGE_BITS  (AGE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a request is in flight");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tdata[4]))
      else $error("hit response reports an eviction");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.look, cmd.scan, cmd.write, cmd.load}))
      else $error("more than one datapath command at once");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for the lru page replacement core
// ----------------------------------------------------------------------------
// page references go in on the request stream, and a predictor tracks frame
// contents, ages and the fault count to work out each response. responses are
// compared field by field in order. test tasks cover page zero, filling and
// hitting the frames, eviction with ages at their maximum, and a long random
// reference stream with a receiver hold-off.
// both sides idle at random except in stretches where they stay busy.
// ----------------------------------------------------------------------------
module tb;
   import lrupr_pkg::*;

   localparam int FRAMES        = 4;
   localparam int PAGE_BITS     = 8;
   localparam int AGE_BITS      = 8;
   localparam int IDLE_PCT      = 20;
   localparam int RANDOM_REFS   = 1575;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic                   hit;
      logic [FRAME_IDX_W-1:0] frame;
      logic                   evicted;
      logic [EV_PAGE_W-1:0]   evicted_page;
      logic [FAULT_W-1:0]     faults;
   } page_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // predictor state
   logic [PAGE_BITS-1:0]  resident_page [FRAMES];
   logic [AGE_BITS-1:0]   frame_age [FRAMES];
   logic [FAULT_W-1:0]    fault_total;

   page_outcome_type      page_outcomes [$];

   bit                    quiet = 1'b0;
   int                    hold_request = 0;
   int                    hold_left = 0;
   int unsigned           refs_sent = 0;
   int unsigned           rsp_checked = 0;
   int unsigned           hit_count = 0;
   int unsigned           evict_count = 0;
   int unsigned           mismatches = 0;
   int unsigned           idle_count = 0;

   lru_page_replacement_core #(
      .FRAMES   (FRAMES),
      .PAGE_BITS(PAGE_BITS),
      .AGE_BITS (AGE_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   // updates frames, ages and fault count for one reference
   function automatic page_outcome_type replace_page(input logic [REQ_DATA_W-1:0] page_in);
      page_outcome_type     res;
      logic [PAGE_BITS-1:0] page;
      logic [AGE_BITS-1:0]  best;
      int                   slot;
      bit                   found;
      bit                   empty;
      res = '0;
      page = PAGE_BITS'(page_in);
      slot = 0;
      found = 1'b0;
      empty = 1'b0;
      if (page != 0) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (!found && resident_page[i] == page) begin
               slot = i;
               found = 1'b1;
            end
         end
         if (found) begin
            res.hit = 1'b1;
            for (int i = 0; i < FRAMES; i++) begin
               if (i == slot) begin
                  frame_age[i] = '0;
               end else if (resident_page[i] != 0 && frame_age[i] != '1) begin
                  frame_age[i] = frame_age[i] + AGE_BITS'(1);
               end
            end
         end else begin
            if (fault_total != FAULT_MAX) begin
               fault_total = fault_total + FAULT_W'(1);
            end
            for (int i = 0; i < FRAMES; i++) begin
               if (resident_page[i] != 0) begin
                  if (frame_age[i] != '1) begin
                     frame_age[i] = frame_age[i] + AGE_BITS'(1);
                  end
               end else if (!empty) begin
                  empty = 1'b1;
                  slot = i;
               end
            end
            if (!empty) begin
               best = '0;
               slot = 0;
               for (int i = 0; i < FRAMES; i++) begin
                  if (frame_age[i] >= best) begin
                     best = frame_age[i];
                     slot = i;
                  end
               end
               res.evicted = 1'b1;
               res.evicted_page = EV_PAGE_W'(resident_page[slot]);
            end
            resident_page[slot] = page;
            frame_age[slot] = '0;
         end
      end
      res.frame = FRAME_IDX_W'(slot);
      res.faults = fault_total;
      return res;
   endfunction

   task automatic send_page(input logic [REQ_DATA_W-1:0] page);
      req_tvalid <= 1'b1;
      req_tdata <= page;
      do @(posedge clock); while (!req_tready);
      page_outcomes.push_back(replace_page(page));
      refs_sent++;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // receiver: random stalls, quiet stretches and a long hold-off on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (reset || quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // response checker
   always @(posedge clock) begin
      page_outcome_type want;
      page_outcome_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit = rsp_tuser;
         got.frame = rsp_tdata[FRAME_IDX_W-1:0];
         got.evicted = rsp_tdata[FRAME_IDX_W];
         got.evicted_page = rsp_tdata[FRAME_IDX_W+1 +: EV_PAGE_W];
         got.faults = rsp_tdata[FRAME_IDX_W+1+EV_PAGE_W +: FAULT_W];
         if (page_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected response hit=%0d frame=%0d", $time, got.hit,
                        got.frame);
            end
         end else begin
            want = page_outcomes.pop_front();
            rsp_checked++;
            if (want.hit) hit_count++;
            if (want.evicted) evict_count++;
            if (got.hit != want.hit || got.frame != want.frame ||
                got.evicted != want.evicted || got.evicted_page != want.evicted_page ||
                got.faults != want.faults) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: response %0d exp hit=%0d frame=%0d ev=%0d page=%0d faults=%0d",
                           $time, rsp_checked, want.hit, want.frame, want.evicted,
                           want.evicted_page, want.faults);
                  $display("%0t: response %0d got hit=%0d frame=%0d ev=%0d page=%0d faults=%0d",
                           $time, rsp_checked, got.hit, got.frame, got.evicted,
                           got.evicted_page, got.faults);
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a handshake", idle_count);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   task automatic test_page_zero();
      send_page(8'd0);
   endtask

   task automatic test_fill_hit_evict();
      send_page(8'd1);
      send_page(8'd255);
      send_page(8'd128);
      send_page(8'd2);
      send_page(8'd255);
      send_page(8'd1);
      send_page(8'd2);
      send_page(8'd128);
      send_page(8'd0);
      send_page(8'h55);
      send_page(8'hAA);
      send_page(8'h55);
      send_page(8'd7);
      send_page(8'd128);
      send_page(8'd0);
   endtask

   task automatic test_age_saturation();
      send_page(8'd11);
      send_page(8'd12);
      send_page(8'd13);
      send_page(8'd14);
      repeat (300) send_page(8'd11);
      // three frames tied at the top age
      send_page(8'd15);
      send_page(8'd12);
      send_page(8'd13);
      send_page(8'd14);
      send_page(8'd11);
   endtask

   task automatic test_random_refs();
      int unsigned               base;
      int unsigned               r;
      logic [REQ_DATA_W-1:0]     page;
      base = $urandom_range(1, 250);
      for (int n = 0; n < RANDOM_REFS; n++) begin
         if (n % 50 == 0) base = $urandom_range(1, 250);
         if (n == 600) hold_request = HOLD_CYCLES;
         quiet = (n >= 1000 && n < 1300);
         r = $urandom_range(99);
         if (r < 5) begin
            page = '0;
         end else if (r < 30) begin
            page = REQ_DATA_W'($urandom_range(1, 255));
         end else begin
            page = REQ_DATA_W'(base + $urandom_range(0, 5));
         end
         send_page(page);
      end
      quiet = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < FRAMES; i++) begin
         resident_page[i] = '0;
         frame_age[i] = '0;
      end
      fault_total = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_page_zero();
      test_fill_hit_evict();
      test_age_saturation();
      test_random_refs();
      req_tvalid <= 1'b0;
      while (page_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (page_outcomes.size() != 0) mismatches++;
      $display("covered %0d page references: %0d hits, %0d evictions, random and directed",
               refs_sent, hit_count, evict_count);
      $display("ages driven to saturation, long receiver hold-off, %0d responses checked",
               rsp_checked);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
